// ===== sv/ppsd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppsd_pkg
// Shared types and constants of the PPM-sum frame decoder.
// ----------------------------------------------------------------------------
package ppsd_pkg;

    // Field widths
    localparam int WIDTH_W    = 16;  // measured pulse width
    localparam int VALUE_W    = 12;  // captured channel value
    localparam int IDX_W      = 4;   // channel index in a frame
    localparam int COUNT_W    = 5;   // channel count of a frame
    localparam int STORE_DEPTH = 16; // most channels a frame can carry

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [15:0]        SYNC_GAP_RST = 16'd2700;
    localparam logic [11:0]        PULSE_MIN_RST = 12'd700;
    localparam logic [11:0]        PULSE_MAX_RST = 12'd2300;
    localparam logic [COUNT_W-1:0] MIN_CHAN_RST = 5'd5;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_GAP  = 4'd0,
        CFG_PULSE_MIN = 4'd1,
        CFG_PULSE_MAX = 4'd2,
        CFG_MIN_CHAN  = 4'd3
    } cfg_idx_t;

    // Current register contents
    typedef struct packed {
        logic [15:0]        sync_gap_us;
        logic [11:0]        pulse_min_us;
        logic [11:0]        pulse_max_us;
        logic [COUNT_W-1:0] min_channels;
    } cfg_t;

    // Input beat
    typedef struct packed {
        logic [WIDTH_W-1:0] width_us;
    } pulse_t;

    // Output beat
    typedef struct packed {
        logic [IDX_W-1:0]   channel_index;
        logic [VALUE_W-1:0] channel_value;
        logic [COUNT_W-1:0] channel_count;
        logic               last_channel;
    } chan_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SHOW
    } state_t;

endpackage

// ===== sv/ppsd_stream_if.sv =====
// ----------------------------------------------------------------------------
// ppsd_stream_if
// Valid/ready stream channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface ppsd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// ===== sv/ppsd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ppsd_cfg_regs
// Configuration register file: sync gap, pulse window and minimum channels.
// ----------------------------------------------------------------------------
module ppsd_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [ppsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppsd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ppsd_pkg::cfg_t                    cfg
);

    ppsd_pkg::cfg_t cfg_reg;
    ppsd_pkg::cfg_t cfg_next;

    // Decode the write; indexes beyond the list change nothing
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (ppsd_pkg::cfg_idx_t'(cfg_index))
                ppsd_pkg::CFG_SYNC_GAP:  cfg_next.sync_gap_us  = cfg_data;
                ppsd_pkg::CFG_PULSE_MIN: cfg_next.pulse_min_us = cfg_data[11:0];
                ppsd_pkg::CFG_PULSE_MAX: cfg_next.pulse_max_us = cfg_data[11:0];
                ppsd_pkg::CFG_MIN_CHAN:
                    cfg_next.min_channels = cfg_data[ppsd_pkg::COUNT_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_gap_us  <= ppsd_pkg::SYNC_GAP_RST;
            cfg_reg.pulse_min_us <= ppsd_pkg::PULSE_MIN_RST;
            cfg_reg.pulse_max_us <= ppsd_pkg::PULSE_MAX_RST;
            cfg_reg.min_channels <= ppsd_pkg::MIN_CHAN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/ppsd_capture_mem.sv =====
// ----------------------------------------------------------------------------
// ppsd_capture_mem
// Capture store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ppsd_capture_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [ADDR_W-1:0]                wr_addr,
    input  logic [ppsd_pkg::VALUE_W-1:0]     wr_data,
    input  logic                             rd_en,
    input  logic [ADDR_W-1:0]                rd_addr,
    output logic [ppsd_pkg::VALUE_W-1:0]     rd_data
);

    logic [ppsd_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [ppsd_pkg::VALUE_W-1:0] rd_data_reg;

    // Write the captured pulse
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read of the addressed entry
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/ppm_sum_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// ppm_sum_frame_decoder_unit
// PPM-sum frame decoder: captures channel pulses and emits whole frames.
// ----------------------------------------------------------------------------
// Each input beat is one pulse width in microseconds. A pulse that is only
// captured, skipped or ignored keeps the unit idle, so ready stays high.
// A pulse that completes a frame (the sync gap after enough channels, or
// the channel limit) holds ready low while the frame is read out of the
// capture store: for each channel a fetch state reads the store, then a
// show state presents the beat until the output side takes it.
// The store needs no clearing after reset: an entry is read only after it
// was written in the current frame.
// ----------------------------------------------------------------------------
module ppm_sum_frame_decoder_unit #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [ppsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppsd_pkg::CFG_DATA_W-1:0]  cfg_data,
    ppsd_stream_if.sink                      pulse,
    ppsd_stream_if.source                    chan
);

    localparam int CHAN_LIMIT = (MAX_CHANNELS > ppsd_pkg::STORE_DEPTH) ?
                                ppsd_pkg::STORE_DEPTH : MAX_CHANNELS;
    localparam int ADDR_W = $clog2(CHAN_LIMIT);
    localparam int POS_W  = $clog2(CHAN_LIMIT + 1);
    localparam int CW     = ppsd_pkg::COUNT_W;

    ppsd_pkg::cfg_t   cfg;
    ppsd_pkg::state_t state_reg, state_next;

    logic                          in_sync_reg, in_sync_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [CW-1:0]                 frame_cnt_reg, frame_cnt_next;
    logic [ppsd_pkg::IDX_W-1:0]    rd_idx_reg, rd_idx_next;

    logic [ppsd_pkg::WIDTH_W-1:0]  width;
    logic                          in_beat, out_beat;
    logic                          is_gap, in_window, capture;
    logic [POS_W-1:0]              pos_inc;
    logic                          hit_limit, gap_emit, start;
    logic                          rd_en, last;
    logic [ppsd_pkg::VALUE_W-1:0]  rd_data;

    ppsd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ppsd_capture_mem #(
        .DEPTH  (CHAN_LIMIT),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (capture),
        .wr_addr (pos_reg[ADDR_W-1:0]),
        .wr_data (width[ppsd_pkg::VALUE_W-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // Classify the incoming pulse
    always_comb
    begin
        width     = pulse.payload.width_us;
        in_beat   = pulse.valid && pulse.ready;
        out_beat  = chan.valid && chan.ready;
        is_gap    = width >= cfg.sync_gap_us;
        in_window = (width > {4'd0, cfg.pulse_min_us}) &&
                    (width < {4'd0, cfg.pulse_max_us});
        capture   = in_beat && !is_gap && in_sync_reg && in_window;
        pos_inc   = pos_reg + POS_W'(1);
        hit_limit = capture && (pos_inc == POS_W'(CHAN_LIMIT));
        gap_emit  = in_beat && is_gap && in_sync_reg &&
                    (pos_reg != '0) && (CW'(pos_reg) >= cfg.min_channels);
        start     = gap_emit || hit_limit;
        last      = (CW'(rd_idx_reg) + CW'(1)) == frame_cnt_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppsd_pkg::ST_IDLE:
                if (start)
                begin
                    state_next = ppsd_pkg::ST_FETCH;
                end
            ppsd_pkg::ST_FETCH:
                state_next = ppsd_pkg::ST_SHOW;
            ppsd_pkg::ST_SHOW:
                if (out_beat)
                begin
                    state_next = last ? ppsd_pkg::ST_IDLE : ppsd_pkg::ST_FETCH;
                end
            default:
                state_next = ppsd_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the controller
    always_comb
    begin
        pulse.ready = (state_reg == ppsd_pkg::ST_IDLE);
        rd_en       = (state_reg == ppsd_pkg::ST_FETCH);
        chan.valid  = (state_reg == ppsd_pkg::ST_SHOW);
        chan.payload.channel_index = rd_idx_reg;
        chan.payload.channel_value = rd_data;
        chan.payload.channel_count = frame_cnt_reg;
        chan.payload.last_channel  = last;
    end

    // Advance sync, slot and readout state
    always_comb
    begin
        in_sync_next   = in_sync_reg;
        pos_next       = pos_reg;
        frame_cnt_next = frame_cnt_reg;
        rd_idx_next    = rd_idx_reg;
        priority if (in_beat && is_gap)
        begin
            in_sync_next   = 1'b1;
            pos_next       = '0;
            frame_cnt_next = CW'(pos_reg);
        end
        else if (hit_limit)
        begin
            in_sync_next   = 1'b0;
            pos_next       = '0;
            frame_cnt_next = CW'(CHAN_LIMIT);
        end
        else if (capture)
        begin
            pos_next = pos_inc;
        end
        else
        begin
            pos_next = pos_reg;
        end
        if (start)
        begin
            rd_idx_next = '0;
        end
        else if (out_beat)
        begin
            rd_idx_next = rd_idx_reg + ppsd_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppsd_pkg::ST_IDLE;
            in_sync_reg   <= 1'b0;
            pos_reg       <= '0;
            frame_cnt_reg <= '0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            in_sync_reg   <= in_sync_next;
            pos_reg       <= pos_next;
            frame_cnt_reg <= frame_cnt_next;
            rd_idx_reg    <= rd_idx_next;
        end
    end

endmodule

// ===== sv/ppsd_checker.sv =====
// ----------------------------------------------------------------------------
// ppsd_checker
// Port-level checks of the PPM-sum frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ppsd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [ppsd_pkg::IDX_W-1:0]       out_index,
    input logic [ppsd_pkg::VALUE_W-1:0]     out_value,
    input logic [ppsd_pkg::COUNT_W-1:0]     out_count,
    input logic                             out_last
);

    // A stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_index) &&
            $stable(out_value) && $stable(out_count) && $stable(out_last))
    else $error("stalled output beat changed");

    // No new pulse is taken during a frame readout
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
    else $error("input ready during frame readout");

    // Last marker sits on the final channel only
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_last == ({1'b0, out_index} + 5'd1 == out_count)))
    else $error("last marker does not match channel count");

    // Index stays inside the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, out_index} < out_count))
    else $error("channel index beyond frame count");

    // Input reopens right after the final channel
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("input not ready after frame end");

endmodule

bind ppm_sum_frame_decoder_unit ppsd_checker u_ppsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pulse.ready),
    .out_valid (chan.valid),
    .out_ready (chan.ready),
    .out_index (chan.payload.channel_index),
    .out_value (chan.payload.channel_value),
    .out_count (chan.payload.channel_count),
    .out_last  (chan.payload.last_channel)
);
